>>> rtl/ladder_keypad_number_decoder_macros.svh
// Assertion macros shared by the keypad decoder modules.
`ifndef LADDER_KEYPAD_NUMBER_DECODER_MACROS_SVH
`define LADDER_KEYPAD_NUMBER_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkd assertion failed");

`endif

>>> rtl/lkd_pkg.sv
package lkd_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int LEVEL_W      = 8;
    localparam int KEY_W        = 5;
    localparam int TABLE_LEVELS = 16;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [KEY_W-1:0]    t_key;

    localparam t_key   NO_KEY    = 5'd16;
    localparam t_level TOL_RESET = 8'd4;

    // Nominal ladder readings, highest voltage first.
    localparam t_level LEVEL_TABLE [TABLE_LEVELS] = '{
        8'd241, 8'd225, 8'd210, 8'd195, 8'd180, 8'd168, 8'd152, 8'd137,
        8'd120, 8'd103, 8'd87,  8'd70,  8'd48,  8'd32,  8'd15,  8'd0
    };

    typedef struct packed {
        logic   fire;
        t_level ref0;
    } t_win_status;

    function automatic t_level abs_diff(input t_level a, input t_level b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> rtl/lkd_sample_if.sv
interface lkd_sample_if import lkd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> rtl/lkd_result_if.sv
interface lkd_result_if import lkd_pkg::*; ();
    logic valid;
    logic ready;
    t_key key_code;
    t_key last_key;

    modport source (output valid, output key_code, output last_key, input ready);
    modport sink   (input valid, input key_code, input last_key, output ready);
endinterface

>>> rtl/lkd_window.sv
`include "ladder_keypad_number_decoder_macros.svh"

module lkd_window import lkd_pkg::*; #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lkd_sample_if.sink   i_sample,
    input  t_level       i_tol,
    input  logic         i_advance,
    output t_win_status  o_status
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0]  NEAR_FULL = CNT_W'(WINDOW_DEPTH - 1);

    logic              r_s1_valid, n_s1_valid;
    t_level            r_s1_sample;
    t_level            r_win [WINDOW_DEPTH];
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_fill, n_fill;

    logic   accept;
    logic   process;
    logic   full;
    logic   stable;
    t_level merged [WINDOW_DEPTH];

    assign i_sample.ready = !r_s1_valid || i_advance;
    assign accept         = i_sample.valid && i_sample.ready;
    assign process        = r_s1_valid && i_advance;

    // The window as it stands once the pending sample has been written.
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            merged[i] = (r_slot == SLOT_W'(i)) ? r_s1_sample : r_win[i];
        end
    end

    always_comb begin
        stable = 1'b1;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (abs_diff(merged[0], merged[i]) >= i_tol) begin
                stable = 1'b0;
            end
        end
    end

    assign full          = (r_fill >= NEAR_FULL);
    assign o_status.fire = process && full && stable;
    assign o_status.ref0 = merged[0];

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_slot     = r_slot;
        n_fill     = r_fill;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (process) begin
            n_s1_valid = 1'b0;
        end
        if (o_status.fire) begin
            // A result restarts the window so the next one needs fresh samples.
            n_slot = '0;
            n_fill = '0;
        end else if (process) begin
            n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            n_fill = (r_fill == FULL_CNT) ? FULL_CNT : r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_slot     <= '0;
            r_fill     <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_slot     <= n_slot;
            r_fill     <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= i_sample.adc_sample[SAMPLE_W-1:SAMPLE_W-LEVEL_W];
        end
        if (process) begin
            r_win[r_slot] <= r_s1_sample;
        end
    end

    `LKD_ASSERT_NEXT(a_fire_clears_fill, i_clk, i_rst_n, o_status.fire, r_fill == '0)
    `LKD_ASSERT_SAME(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= FULL_CNT)
    `LKD_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_valid && !i_advance,
                     r_s1_valid && $stable(r_s1_sample))

endmodule

>>> rtl/lkd_match.sv
`include "ladder_keypad_number_decoder_macros.svh"

module lkd_match import lkd_pkg::*; #(
    parameter int LEVEL_COUNT = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_win_status   i_status,
    input  t_level        i_tol,
    output logic          o_advance,
    lkd_result_if.source  o_result
);

    localparam int SEARCH = (LEVEL_COUNT < TABLE_LEVELS) ? LEVEL_COUNT : TABLE_LEVELS;

    logic r_out_valid, n_out_valid;
    t_key r_key;
    t_key r_last, n_last;
    t_key key;

    // Scanning from the bottom of the table up leaves the first match in table order.
    always_comb begin
        key = NO_KEY;
        for (int i = SEARCH - 1; i >= 0; i--) begin
            if (abs_diff(i_status.ref0, LEVEL_TABLE[i]) < i_tol) begin
                key = KEY_W'(i);
            end
        end
    end

    assign o_advance = !r_out_valid || o_result.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_last      = r_last;
        if (i_status.fire) begin
            n_out_valid = 1'b1;
            if (key != NO_KEY) begin
                n_last = key;
            end
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= NO_KEY;
        end else begin
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_status.fire) begin
            r_key <= key;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.key_code = r_key;
    assign o_result.last_key = r_last;

    `LKD_ASSERT_SAME(a_key_range, i_clk, i_rst_n, r_out_valid, r_key <= NO_KEY)
    `LKD_ASSERT_SAME(a_last_follows_key, i_clk, i_rst_n, r_out_valid && (r_key != NO_KEY),
                     r_last == r_key)
    `LKD_ASSERT_NEXT(a_last_sticks, i_clk, i_rst_n, r_last != NO_KEY, r_last != NO_KEY)

endmodule

>>> rtl/ladder_keypad_number_decoder.sv
// An accepted sample is held in the input stage register; its key is then registered in the result register.
// Throughput: one sample per cycle while results are taken; the window update, stability check and level
// search all fit between the input stage register and the result register.
// While a result waits, the input stage holds its sample; an empty stage still takes one.
// Reset (synchronous, active low): window empty, last key none, tolerance 4.

module ladder_keypad_number_decoder import lkd_pkg::*; #(
    parameter int WINDOW_DEPTH = 8,
    parameter int LEVEL_COUNT  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lkd_sample_if.sink    i_sample,
    lkd_result_if.source  o_result,
    input  logic          i_cfg_we,
    input  t_level        i_cfg_wdata
);

    t_level      r_tol, n_tol;
    t_win_status status;
    logic        advance;

    assign n_tol = i_cfg_we ? i_cfg_wdata : r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else begin
            r_tol <= n_tol;
        end
    end

    lkd_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (i_sample),
        .i_tol     (r_tol),
        .i_advance (advance),
        .o_status  (status)
    );

    lkd_match #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_status  (status),
        .i_tol     (r_tol),
        .o_advance (advance),
        .o_result  (o_result)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lkd_pkg::*;

    localparam int WINDOW_DEPTH  = 8;
    localparam int LEVEL_COUNT   = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 110;
    localparam int DIRECTED_ROWS = 25;

    localparam t_level LADDER [16] = '{
        8'd241, 8'd225, 8'd210, 8'd195, 8'd180, 8'd168, 8'd152, 8'd137,
        8'd120, 8'd103, 8'd87,  8'd70,  8'd48,  8'd32,  8'd15,  8'd0
    };

    typedef struct packed {
        t_key key_code;
        t_key last_key;
    } t_keypress;

    typedef struct packed {
        t_sample   sample;
        logic      pinned;
        t_keypress press;
    } t_stim_row;

    // Rows with pinned set carry the keypress expected at that sample.
    localparam t_stim_row STIM_ROWS [DIRECTED_ROWS] = '{
        '{10'h3FF, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h3FC, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h3FF, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h3FC, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h3FF, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h3FC, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h3FE, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h3FD, 1'b1, '{NO_KEY, NO_KEY}},
        '{10'h000, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h003, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h000, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h003, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h001, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h003, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h000, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h002, 1'b1, '{5'd15, 5'd15}},
        '{10'h3C4, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h3C7, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h3C4, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h3C7, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h3C5, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h3C6, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h3C4, 1'b0, '{NO_KEY, NO_KEY}}, '{10'h258, 1'b0, '{NO_KEY, NO_KEY}},
        '{10'h3C5, 1'b0, '{NO_KEY, NO_KEY}}
    };

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    t_level cfg_wdata;

    lkd_sample_if smp_if ();
    lkd_result_if res_if ();

    ladder_keypad_number_decoder #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .LEVEL_COUNT  (LEVEL_COUNT)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample    (smp_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predictor state.
    t_level      seen_levels [WINDOW_DEPTH];
    int unsigned ring_pos;
    int unsigned ring_fill;
    t_key        held_key;
    int unsigned tol_now;

    t_keypress   pending_presses [$];
    int unsigned mismatches;
    int unsigned fed_items;
    bit          tx_steady;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned spread(input int unsigned a, input int unsigned b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Returns 1 when the sample completes a stable window and so yields a keypress.
    function automatic bit decode_sample(input t_sample s, output t_keypress kp);
        int unsigned ref0;
        int unsigned hit;
        bit steady;
        seen_levels[ring_pos] = s[SAMPLE_W-1:2];
        ring_pos = (ring_pos + 1) % WINDOW_DEPTH;
        if (ring_fill < WINDOW_DEPTH) ring_fill++;
        kp = '{key_code: NO_KEY, last_key: held_key};
        if (ring_fill < WINDOW_DEPTH) return 1'b0;
        ref0 = seen_levels[0];
        steady = 1'b1;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (spread(ref0, seen_levels[i]) >= tol_now) steady = 1'b0;
        end
        if (!steady) return 1'b0;
        hit = NO_KEY;
        // Walk backwards so that the first level in table order wins.
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (spread(ref0, LADDER[i]) < tol_now) hit = i;
        end
        if (hit != NO_KEY) held_key = t_key'(hit);
        ring_pos  = 0;
        ring_fill = 0;
        kp.key_code = t_key'(hit);
        kp.last_key = held_key;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_sample(input t_sample s, input bit pinned, input t_keypress fixed);
        int unsigned gap;
        t_keypress kp;
        bit fired;
        if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid      <= 1'b1;
        smp_if.adc_sample <= s;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        fed_items++;
        fired = decode_sample(s, kp);
        if (pinned) begin
            pending_presses.push_back(fixed);
        end else if (fired) begin
            pending_presses.push_back(kp);
        end
    endtask

    task automatic send_random(input t_sample s);
        send_sample(s, 1'b0, '0);
    endtask

    // Eight samples that all lie within the tolerance of one another, optionally
    // with one sample replaced by a random reading.
    task automatic send_press(input bit broken);
        int base;
        int v;
        int unsigned spoil;
        if ($urandom_range(0, 1) == 0) begin
            base = int'(LADDER[$urandom_range(0, 15)]) + int'($urandom_range(0, 2 * tol_now))
                   - int'(tol_now);
        end else begin
            base = int'($urandom_range(0, 255));
        end
        if (base < 0) base = 0;
        if (base > 255) base = 255;
        spoil = broken ? $urandom_range(0, WINDOW_DEPTH - 1) : WINDOW_DEPTH;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            v = base + int'($urandom_range(0, tol_now - 1));
            if (v > 255) v = 255;
            if (i == spoil) begin
                send_random(t_sample'($urandom_range(0, 1023)));
            end else begin
                send_random({t_level'(v), 2'($urandom_range(0, 3))});
            end
        end
    endtask

    // Stops the sender and waits until every keypress has come back.
    task automatic settle();
        smp_if.valid <= 1'b0;
        while (pending_presses.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tolerance(input t_level value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        tol_now = value;
    endtask

    initial begin : stimulus
        t_level tol_plan [5];
        int unsigned pick;
        int unsigned target;
        smp_if.valid      <= 1'b0;
        smp_if.adc_sample <= '0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        rst_n             <= 1'b0;
        mismatches = 0;
        fed_items  = 0;
        tx_steady  = 1'b0;
        ring_pos   = 0;
        ring_fill  = 0;
        held_key   = NO_KEY;
        tol_now    = TOL_RESET;
        foreach (seen_levels[i]) seen_levels[i] = '0;
        tol_plan = '{8'd1, 8'd255, t_level'($urandom_range(2, 40)), 8'd12, 8'd4};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_sample(STIM_ROWS[r].sample, STIM_ROWS[r].pinned, STIM_ROWS[r].press);
        end

        foreach (tol_plan[p]) begin
            settle();
            write_tolerance(tol_plan[p]);
            target = fed_items + PHASE_ITEMS;
            while (fed_items < target) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    send_press(1'b0);
                end else if (pick < 17) begin
                    send_press(1'b1);
                end else begin
                    repeat ($urandom_range(1, 4)) send_random(t_sample'($urandom_range(0, 1023)));
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Result side: sometimes ready waits for valid and then holds off, sometimes
    // it is already high when the result turns up.
    initial begin : result_sink
        int unsigned hold;
        bit steady;
        steady = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0) steady = !steady;
            hold = steady ? 0 : $urandom_range(0, 8);
            if (hold != 0) begin
                res_if.ready <= 1'b0;
                @(posedge clk);
                while (!res_if.valid) @(posedge clk);
                repeat (hold - 1) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_check
        t_keypress want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_presses.size() == 0) begin
                report_mismatch("key_code of unexpected transaction", res_if.key_code, -1);
            end else begin
                want = pending_presses.pop_front();
                if (res_if.key_code !== want.key_code) begin
                    report_mismatch("key_code", res_if.key_code, want.key_code);
                end
                if (res_if.last_key !== want.last_key) begin
                    report_mismatch("last_key", res_if.last_key, want.last_key);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/lkd_pkg.sv
rtl/lkd_sample_if.sv
rtl/lkd_result_if.sv
rtl/lkd_window.sv
rtl/lkd_match.sv
rtl/ladder_keypad_number_decoder.sv
test/tb_top.sv
